>>> design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define AST_CHK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define AST_CHK_ALL(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/nqfs_pkg.sv
package nqfs_pkg;

    localparam int MAX_SIZE_DEF = 16;
    localparam int SIZE_W       = 5;
    localparam int ROW_W        = 4;
    localparam int PC_W         = 5;

    typedef enum logic [3:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NOT_ACCEPT,
        COND_N_ZERO,
        COND_CAND_GE_N,
        COND_CHK_EQ_COL,
        COND_NO_CONFLICT,
        COND_COL_LAST,
        COND_COL_ZERO,
        COND_OUT_BUSY,
        COND_EMIT_LAST
    } cond_t;

    typedef struct packed {
        cond_t            cond;
        logic [PC_W-1:0]  target;
        logic             in_ready;
        logic             start;
        logic             chk_clr;
        logic             chk_inc;
        logic             cand_clr;
        logic             cand_inc;
        logic             cand_load;
        logic             col_inc;
        logic             col_dec;
        logic             ram_we;
        logic             rd_colm1;
        logic             out_ok;
        logic             out_fail;
    } ctrl_word_t;

    typedef struct packed {
        logic accept;
        logic n_zero;
        logic cand_ge_n;
        logic chk_eq_col;
        logic no_conflict;
        logic col_last;
        logic col_zero;
        logic out_busy;
        logic emit_last;
    } flags_t;

    localparam logic [PC_W-1:0] STEP_IDLE      = 5'd0;
    localparam logic [PC_W-1:0] STEP_SIZE_CHK  = 5'd1;
    localparam logic [PC_W-1:0] STEP_TRY       = 5'd2;
    localparam logic [PC_W-1:0] STEP_CHECK     = 5'd3;
    localparam logic [PC_W-1:0] STEP_TEST      = 5'd4;
    localparam logic [PC_W-1:0] STEP_NEXT_ROW  = 5'd5;
    localparam logic [PC_W-1:0] STEP_PLACE     = 5'd6;
    localparam logic [PC_W-1:0] STEP_ADVANCE   = 5'd7;
    localparam logic [PC_W-1:0] STEP_BACK      = 5'd8;
    localparam logic [PC_W-1:0] STEP_POP       = 5'd9;
    localparam logic [PC_W-1:0] STEP_RESUME    = 5'd10;
    localparam logic [PC_W-1:0] STEP_EMIT      = 5'd11;
    localparam logic [PC_W-1:0] STEP_EMIT_RD   = 5'd12;
    localparam logic [PC_W-1:0] STEP_EMIT_OUT  = 5'd13;
    localparam logic [PC_W-1:0] STEP_EMIT_NEXT = 5'd14;
    localparam logic [PC_W-1:0] STEP_EMIT_LOOP = 5'd15;
    localparam logic [PC_W-1:0] STEP_FAIL      = 5'd16;
    localparam logic [PC_W-1:0] STEP_FAIL_END  = 5'd17;

    // microprogram
    function automatic ctrl_word_t ucode_rom(input logic [PC_W-1:0] pc);
        ctrl_word_t w;
        w        = '0;
        w.cond   = COND_NEVER;
        w.target = STEP_IDLE;
        unique case (pc)
            STEP_IDLE:
            begin
                w.in_ready = 1'b1;
                w.start    = 1'b1;
                w.cond     = COND_NOT_ACCEPT;
                w.target   = STEP_IDLE;
            end
            STEP_SIZE_CHK:
            begin
                w.cond   = COND_N_ZERO;
                w.target = STEP_FAIL;
            end
            STEP_TRY:
            begin
                w.chk_clr = 1'b1;
                w.cond    = COND_CAND_GE_N;
                w.target  = STEP_BACK;
            end
            STEP_CHECK:
            begin
                w.cond   = COND_CHK_EQ_COL;
                w.target = STEP_PLACE;
            end
            STEP_TEST:
            begin
                w.chk_inc = 1'b1;
                w.cond    = COND_NO_CONFLICT;
                w.target  = STEP_CHECK;
            end
            STEP_NEXT_ROW:
            begin
                w.cand_inc = 1'b1;
                w.cond     = COND_ALWAYS;
                w.target   = STEP_TRY;
            end
            STEP_PLACE:
            begin
                w.ram_we = 1'b1;
                w.cond   = COND_COL_LAST;
                w.target = STEP_EMIT;
            end
            STEP_ADVANCE:
            begin
                w.col_inc  = 1'b1;
                w.cand_clr = 1'b1;
                w.cond     = COND_ALWAYS;
                w.target   = STEP_TRY;
            end
            STEP_BACK:
            begin
                w.cond   = COND_COL_ZERO;
                w.target = STEP_FAIL;
            end
            STEP_POP:
            begin
                w.col_dec  = 1'b1;
                w.rd_colm1 = 1'b1;
            end
            STEP_RESUME:
            begin
                w.cand_load = 1'b1;
                w.cond      = COND_ALWAYS;
                w.target    = STEP_TRY;
            end
            STEP_EMIT:
            begin
                w.chk_clr = 1'b1;
            end
            STEP_EMIT_RD:
            begin
                w.cond = COND_NEVER;
            end
            STEP_EMIT_OUT:
            begin
                w.out_ok = 1'b1;
                w.cond   = COND_OUT_BUSY;
                w.target = STEP_EMIT_OUT;
            end
            STEP_EMIT_NEXT:
            begin
                w.chk_inc = 1'b1;
                w.cond    = COND_EMIT_LAST;
                w.target  = STEP_IDLE;
            end
            STEP_EMIT_LOOP:
            begin
                w.cond   = COND_ALWAYS;
                w.target = STEP_EMIT_RD;
            end
            STEP_FAIL:
            begin
                w.out_fail = 1'b1;
                w.cond     = COND_OUT_BUSY;
                w.target   = STEP_FAIL;
            end
            STEP_FAIL_END:
            begin
                w.cond   = COND_ALWAYS;
                w.target = STEP_IDLE;
            end
            default:
            begin
                w.cond   = COND_ALWAYS;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

>>> design/nqfs_ram.sv
module nqfs_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> design/nqfs_seq.sv
module nqfs_seq import nqfs_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  flags_t     flags,
    output ctrl_word_t ctrl
);

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            taken;

    assign ctrl = ucode_rom(pc_reg);

    always_comb
    begin
        case (ctrl.cond)
            COND_ALWAYS:      taken = 1'b1;
            COND_NOT_ACCEPT:  taken = !flags.accept;
            COND_N_ZERO:      taken = flags.n_zero;
            COND_CAND_GE_N:   taken = flags.cand_ge_n;
            COND_CHK_EQ_COL:  taken = flags.chk_eq_col;
            COND_NO_CONFLICT: taken = flags.no_conflict;
            COND_COL_LAST:    taken = flags.col_last;
            COND_COL_ZERO:    taken = flags.col_zero;
            COND_OUT_BUSY:    taken = flags.out_busy;
            COND_EMIT_LAST:   taken = flags.emit_last;
            default:          taken = 1'b0;
        endcase
        pc_next = taken ? ctrl.target : pc_reg + PC_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= STEP_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

>>> design/n_queens_first_solution_core.sv
// Search: size check, then each row tried is tested against every earlier column in turn;
// a rejected row moves to the next row, a placed queen to the next column, and a backtrack
// resumes the previous column past its queen; one result per column follows, held on stall.
// Throughput: one request per completed search; the microcode sequencer is the limit.
// Reset (rst_n, async, active low) clears the sequencer, counters and output valid;
// the board store (1R1W RAM, registered read) is not cleared.
module n_queens_first_solution_core import nqfs_pkg::*; #(
    parameter int MAX_SIZE = MAX_SIZE_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [4:0] board_size
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [3:0] column_index, [7:4] queen_row
    output logic       m_tuser,   // [0] found
    output logic       m_tlast
);

    `include "assert_macros.svh"

    localparam int RAM_AW = $clog2(MAX_SIZE);

    ctrl_word_t ctrl;
    flags_t     flags;

    logic [SIZE_W-1:0] n_reg,    n_next;
    logic [SIZE_W-1:0] col_reg,  col_next;
    logic [SIZE_W-1:0] cand_reg, cand_next;
    logic [ROW_W-1:0]  chk_reg,  chk_next;

    logic              m_tvalid_reg, m_tvalid_next;
    logic              found_reg;
    logic [ROW_W-1:0]  col_idx_reg;
    logic [ROW_W-1:0]  row_reg;
    logic              last_reg;

    logic [SIZE_W-1:0] size_in;
    logic [SIZE_W-1:0] size_sat;
    logic [SIZE_W-1:0] col_m1;
    logic [SIZE_W-1:0] chk_ext;
    logic [SIZE_W-1:0] row_ext;
    logic [SIZE_W-1:0] dcol;
    logic [SIZE_W-1:0] drow;
    logic [ROW_W-1:0]  rd_row;
    logic [RAM_AW-1:0] raddr;
    logic              accept;
    logic              out_busy;
    logic              out_load;

    assign size_in  = s_tdata[SIZE_W-1:0];
    assign size_sat = (size_in > SIZE_W'(MAX_SIZE)) ? SIZE_W'(MAX_SIZE) : size_in;

    assign s_tready = ctrl.in_ready;
    assign accept   = s_tvalid && s_tready;
    assign out_busy = m_tvalid_reg && !m_tready;
    assign out_load = (ctrl.out_ok || ctrl.out_fail) && !out_busy;

    assign col_m1  = col_reg - SIZE_W'(1);
    assign chk_ext = {1'b0, chk_reg};
    assign row_ext = {1'b0, rd_row};
    // earlier column is always to the left, so the column distance is positive
    assign dcol    = col_reg - chk_ext;
    assign drow    = (row_ext > cand_reg) ? (row_ext - cand_reg) : (cand_reg - row_ext);

    assign raddr = ctrl.rd_colm1 ? col_m1[RAM_AW-1:0] : chk_reg[RAM_AW-1:0];

    nqfs_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_SIZE)
    ) u_board (
        .clk   (clk),
        .we    (ctrl.ram_we),
        .waddr (col_reg[RAM_AW-1:0]),
        .wdata (cand_reg[ROW_W-1:0]),
        .raddr (raddr),
        .rdata (rd_row)
    );

    always_comb
    begin
        flags.accept      = accept;
        flags.n_zero      = (n_reg == '0);
        flags.cand_ge_n   = (cand_reg >= n_reg);
        flags.chk_eq_col  = (chk_ext == col_reg);
        flags.no_conflict = (row_ext != cand_reg) && (dcol != drow);
        flags.col_last    = (col_reg + SIZE_W'(1) == n_reg);
        flags.col_zero    = (col_reg == '0);
        flags.out_busy    = out_busy;
        flags.emit_last   = (chk_ext + SIZE_W'(1) == n_reg);
    end

    nqfs_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    always_comb
    begin
        n_next    = n_reg;
        col_next  = col_reg;
        cand_next = cand_reg;
        chk_next  = chk_reg;
        if (ctrl.start && accept)
        begin
            n_next    = size_sat;
            col_next  = '0;
            cand_next = '0;
        end
        if (ctrl.chk_clr)
        begin
            chk_next = '0;
        end
        if (ctrl.chk_inc)
        begin
            chk_next = chk_reg + ROW_W'(1);
        end
        if (ctrl.cand_clr)
        begin
            cand_next = '0;
        end
        if (ctrl.cand_inc)
        begin
            cand_next = cand_reg + SIZE_W'(1);
        end
        if (ctrl.cand_load)
        begin
            cand_next = row_ext + SIZE_W'(1);
        end
        if (ctrl.col_inc)
        begin
            col_next = col_reg + SIZE_W'(1);
        end
        if (ctrl.col_dec)
        begin
            col_next = col_m1;
        end

        if (out_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg        <= '0;
            col_reg      <= '0;
            cand_reg     <= '0;
            chk_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            n_reg        <= n_next;
            col_reg      <= col_next;
            cand_reg     <= cand_next;
            chk_reg      <= chk_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            found_reg   <= ctrl.out_ok;
            col_idx_reg <= ctrl.out_ok ? chk_reg : '0;
            row_reg     <= ctrl.out_ok ? rd_row : '0;
            last_reg    <= ctrl.out_fail || flags.emit_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {row_reg, col_idx_reg};
    assign m_tuser  = found_reg;
    assign m_tlast  = last_reg;

    `AST_CHK(a_busy_after_accept, (s_tvalid && s_tready) |=> !s_tready, "request taken while busy")
    `AST_CHK(a_fail_is_last, (m_tvalid && !m_tuser) |-> m_tlast, "no-solution result not last")
    `AST_CHK(a_place_in_range, ctrl.ram_we |-> (cand_reg < n_reg), "queen placed off the board")
    `AST_CHK_ALL(a_no_valid_in_reset, !rst_n |-> !m_tvalid, "result valid during reset")

endmodule
